/* design/mta_pkg.sv */
package mta_pkg;

  localparam int CHANNELS_DEF = 16;

  localparam int CH_W   = 4;
  localparam int VAL_W  = 32;
  localparam int TIME_W = 32;
  localparam int COOL_W = 23;
  localparam int BAND_W = 24;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = COOL_W;

  localparam logic [CFG_IDX_W-1:0] CFG_ALARMS_ENABLED = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN       = CFG_IDX_W'(1);

  localparam logic [COOL_W-1:0] COOL_MIN      = COOL_W'(60);
  localparam logic [COOL_W-1:0] COOL_MAX      = COOL_W'(4294967);
  localparam logic [TIME_W-1:0] COOL_RESET_MS = TIME_W'(3600000);
  localparam logic [TIME_W-1:0] MS_PER_S      = TIME_W'(1000);

  // The band divides by 200 as a shift by 3 and a multiply by the
  // reciprocal of 25, exact for every 29-bit dividend.
  localparam int                BAND_X_W  = 29;
  localparam int                BAND_M_W  = 30;
  localparam int                BAND_SH   = 34;
  localparam logic [BAND_M_W-1:0] BAND_RECIP = BAND_M_W'(687194768);

  localparam int FIFO_DEPTH = 4;

  typedef struct packed {
    logic                     kind;
    logic [CH_W-1:0]          channel;
    logic signed [VAL_W-1:0]  sample_value;
    logic                     sample_valid;
    logic [TIME_W-1:0]        now_ms;
    logic signed [VAL_W-1:0]  min_limit;
    logic signed [VAL_W-1:0]  max_limit;
    logic                     min_present;
    logic                     max_present;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] alarm_channel;
    logic            alarm_on;
    logic            is_reminder;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_item_t;

  typedef struct packed {
    logic                    lo_p;
    logic                    hi_p;
    logic signed [VAL_W-1:0] lo;
    logic signed [VAL_W-1:0] hi;
  } thr_t;

  typedef struct packed {
    logic              active;
    logic [TIME_W-1:0] last_ms;
  } st_t;

  function automatic logic [BAND_W-1:0] band(input logic signed [VAL_W-1:0] t);
    logic [VAL_W-1:0]                  mag;
    logic [BAND_X_W-1:0]               x;
    logic [BAND_X_W+BAND_M_W-1:0]      prod;
    logic [BAND_W-1:0]                 q;
    mag  = t[VAL_W-1] ? VAL_W'(-t) : VAL_W'(t);
    x    = mag[VAL_W-1:3];
    prod = {{BAND_M_W{1'b0}}, x} * {{BAND_X_W{1'b0}}, BAND_RECIP};
    q    = prod[BAND_SH+BAND_W-1:BAND_SH];
    return (q == '0) ? BAND_W'(1) : q;
  endfunction

  function automatic logic [TIME_W-1:0] period_ms(input logic [COOL_W-1:0] sec);
    logic [COOL_W-1:0] c;
    c = sec;
    if (c < COOL_MIN) begin
      c = COOL_MIN;
    end else if (c > COOL_MAX) begin
      c = COOL_MAX;
    end
    return TIME_W'(c) * MS_PER_S;
  endfunction

endpackage

/* design/mta_ifs.sv */
interface mta_in_if;
  logic               valid;
  logic               ready;
  mta_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mta_out_if;
  logic               valid;
  logic               ready;
  mta_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mta_cfg_if;
  logic               valid;
  logic               ready;
  mta_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/multichannel_threshold_alarm.sv */
// Per-channel window alarm with hysteresis and reminder timing.
// The input channel carries sample checks and threshold writes; each accepted
// transaction gives at most one notification on the output channel. The
// configuration channel writes the alarm enable and the cooldown period and
// is always ready; the user must write it only while the block is idle, and
// the block does not enforce this. An accepted transaction passes through
// the stage 1 and stage 2 registers before its notification is written into
// the queue. While input ready is high, one transaction is accepted per
// cycle: thresholds live in one RAM that is read at acceptance and written
// in the next stage, alarm state in a second RAM that is read and written
// one stage later, each with a bypass for the write its read cannot yet see.
// Notifications wait in a four-entry queue. Input ready drops when the
// queued notifications plus the transactions still in the pipeline fill it,
// so a stalled receiver stops input and nothing is lost.
// Reset disables alarms, sets the cooldown to 3600 s and marks every channel
// as having no thresholds and no active alarm through per-entry valid bits;
// input ready is high as soon as reset is released.
module multichannel_threshold_alarm #(
  parameter int CHANNELS = mta_pkg::CHANNELS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mta_in_if.sink     in_ch,
  mta_out_if.source  out_ch,
  mta_cfg_if.sink    cfg_ch
);

  import mta_pkg::*;

  localparam int AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW = FIFO_AW + 1;
  localparam int FIFO_SW = FIFO_CW + 1;
  localparam int THR_W   = $bits(thr_t);
  localparam int ST_W    = $bits(st_t);

  // Configuration registers.
  logic              en_r;
  logic [TIME_W-1:0] period_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r     <= 1'b0;
      period_r <= COOL_RESET_MS;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.data.index)
        CFG_ALARMS_ENABLED: en_r     <= cfg_ch.data.wdata[0];
        CFG_COOLDOWN:       period_r <= period_ms(cfg_ch.data.wdata);
        default: ;
      endcase
    end
  end

  // Acceptance and threshold read.
  logic            acc;
  logic [6:0]      in_ch7;
  logic [AW-1:0]   in_addr;
  logic            in_range;

  assign acc      = in_ch.valid && in_ch.ready;
  assign in_ch7   = 7'(in_ch.data.channel);
  assign in_addr  = in_ch7[AW-1:0];
  assign in_range = in_ch7 < 7'(CHANNELS);

  logic            s1_v_r;
  in_item_t        s1_item_r;
  logic [AW-1:0]   s1_addr_r;
  logic            s1_tv_r;

  logic [CHANNELS-1:0] thr_vld_r;
  logic [CHANNELS-1:0] st_vld_r;

  // Stage 1: threshold write or band computation.
  logic            thr_we;
  thr_t            thr_wdata;
  logic [THR_W-1:0] thr_rd;
  thr_t            thr_cur;
  logic            thr_fw_v_r;
  logic [AW-1:0]   thr_fw_addr_r;
  thr_t            thr_fw_data_r;

  assign thr_we    = s1_v_r && s1_item_r.kind;
  assign thr_wdata = '{lo_p: s1_item_r.min_present, hi_p: s1_item_r.max_present,
                       lo: s1_item_r.min_limit, hi: s1_item_r.max_limit};

  mta_ram #(.WIDTH(THR_W), .DEPTH(CHANNELS)) u_thr_ram (
    .clk   (clk),
    .we    (thr_we),
    .waddr (s1_addr_r),
    .wdata (THR_W'(thr_wdata)),
    .raddr (in_addr),
    .rdata (thr_rd)
  );

  always_comb begin
    if (thr_fw_v_r && thr_fw_addr_r == s1_addr_r) begin
      thr_cur = thr_fw_data_r;
    end else if (s1_tv_r) begin
      thr_cur = thr_t'(thr_rd);
    end else begin
      thr_cur = '0;
    end
  end

  // Stage 2 registers.
  logic                    s2_v_r;
  logic [CH_W-1:0]         s2_ch_r;
  logic [AW-1:0]           s2_addr_r;
  logic signed [VAL_W-1:0] s2_val_r;
  logic                    s2_sv_r;
  logic [TIME_W-1:0]       s2_now_r;
  thr_t                    s2_thr_r;
  logic [BAND_W-1:0]       s2_blo_r;
  logic [BAND_W-1:0]       s2_bhi_r;
  logic                    s2_stv_r;

  logic                    s1_chk;
  assign s1_chk = s1_v_r && !s1_item_r.kind;

  // Stage 2: alarm state read-modify-write.
  logic             st_we;
  st_t              st_nxt;
  logic [ST_W-1:0]  st_rd;
  st_t              st_cur;
  logic             st_fw_v_r;
  logic [AW-1:0]    st_fw_addr_r;
  st_t              st_fw_data_r;

  mta_ram #(.WIDTH(ST_W), .DEPTH(CHANNELS)) u_st_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (s2_addr_r),
    .wdata (ST_W'(st_nxt)),
    .raddr (s1_addr_r),
    .rdata (st_rd)
  );

  always_comb begin
    if (st_fw_v_r && st_fw_addr_r == s2_addr_r) begin
      st_cur = st_fw_data_r;
    end else if (s2_stv_r) begin
      st_cur = st_t'(st_rd);
    end else begin
      st_cur = '0;
    end
  end

  logic signed [VAL_W:0] v33;
  logic signed [VAL_W:0] lo33;
  logic signed [VAL_W:0] hi33;
  logic signed [VAL_W:0] blo33;
  logic signed [VAL_W:0] bhi33;
  logic                  cond;
  logic                  clear;
  logic [TIME_W-1:0]     elapsed;
  logic                  emit;
  logic                  emit_on;
  logic                  emit_rem;

  assign v33     = (VAL_W+1)'(s2_val_r);
  assign lo33    = (VAL_W+1)'($signed(s2_thr_r.lo));
  assign hi33    = (VAL_W+1)'($signed(s2_thr_r.hi));
  assign blo33   = $signed({{(VAL_W+1-BAND_W){1'b0}}, s2_blo_r});
  assign bhi33   = $signed({{(VAL_W+1-BAND_W){1'b0}}, s2_bhi_r});
  assign cond    = (s2_thr_r.lo_p && (v33 < lo33 - blo33)) ||
                   (s2_thr_r.hi_p && (v33 > hi33 + bhi33));
  assign clear   = !(s2_thr_r.lo_p && (v33 < lo33 + blo33)) &&
                   !(s2_thr_r.hi_p && (v33 > hi33 - bhi33));
  assign elapsed = s2_now_r - st_cur.last_ms;

  always_comb begin
    emit     = 1'b0;
    emit_on  = 1'b0;
    emit_rem = 1'b0;
    st_nxt   = st_cur;
    if (s2_v_r) begin
      if (!en_r) begin
        if (st_cur.active) begin
          emit          = 1'b1;
          st_nxt.active = 1'b0;
        end
      end else if ((s2_thr_r.lo_p || s2_thr_r.hi_p) && s2_sv_r) begin
        if (cond && !st_cur.active) begin
          emit           = 1'b1;
          emit_on        = 1'b1;
          st_nxt.active  = 1'b1;
          st_nxt.last_ms = s2_now_r;
        end else if (cond) begin
          if (elapsed >= period_r) begin
            emit           = 1'b1;
            emit_on        = 1'b1;
            emit_rem       = 1'b1;
            st_nxt.last_ms = s2_now_r;
          end
        end else if (st_cur.active && clear) begin
          emit          = 1'b1;
          st_nxt.active = 1'b0;
        end
      end
    end
  end

  assign st_we = emit;

  // Result queue.
  out_item_t          fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r;
  logic [FIFO_AW-1:0] rp_r;
  logic [FIFO_CW-1:0] cnt_r;
  logic               pop;
  logic [FIFO_SW-1:0] inflight;

  assign pop      = out_ch.valid && out_ch.ready;
  assign inflight = FIFO_SW'(cnt_r) + FIFO_SW'(s1_v_r) + FIFO_SW'(s2_v_r);
  assign in_ch.ready  = inflight < FIFO_SW'(FIFO_DEPTH);
  assign out_ch.valid = cnt_r != '0;
  assign out_ch.data  = fifo_r[rp_r];

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      thr_fw_v_r <= 1'b0;
      st_fw_v_r  <= 1'b0;
      thr_vld_r  <= '0;
      st_vld_r   <= '0;
      wp_r       <= '0;
      rp_r       <= '0;
      cnt_r      <= '0;
    end else begin
      s1_v_r     <= acc && in_range;
      s2_v_r     <= s1_chk;
      thr_fw_v_r <= thr_we;
      st_fw_v_r  <= st_we;
      if (thr_we) begin
        thr_vld_r[s1_addr_r] <= 1'b1;
      end
      if (st_we) begin
        st_vld_r[s2_addr_r] <= 1'b1;
      end
      if (emit) begin
        wp_r <= wp_r + FIFO_AW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + FIFO_AW'(1);
      end
      cnt_r <= cnt_r + FIFO_CW'(emit) - FIFO_CW'(pop);
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_item_r <= in_ch.data;
      s1_addr_r <= in_addr;
      s1_tv_r   <= thr_vld_r[in_addr];
    end
    if (thr_we) begin
      thr_fw_addr_r <= s1_addr_r;
      thr_fw_data_r <= thr_wdata;
    end
    if (s1_chk) begin
      s2_ch_r   <= s1_item_r.channel;
      s2_addr_r <= s1_addr_r;
      s2_val_r  <= s1_item_r.sample_value;
      s2_sv_r   <= s1_item_r.sample_valid;
      s2_now_r  <= s1_item_r.now_ms;
      s2_thr_r  <= thr_cur;
      s2_blo_r  <= band(thr_cur.lo);
      s2_bhi_r  <= band(thr_cur.hi);
      s2_stv_r  <= st_vld_r[s1_addr_r];
    end
    if (st_we) begin
      st_fw_addr_r <= s2_addr_r;
      st_fw_data_r <= st_nxt;
    end
    if (emit) begin
      fifo_r[wp_r] <= '{alarm_channel: s2_ch_r, alarm_on: emit_on, is_reminder: emit_rem};
    end
  end

endmodule

/* design/mta_ram.sv */
module mta_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
